/* src/rtt_pkg.sv */
// ============================================================================
// rtt_pkg: retransmit timer table shared types
// Word formats, table entry layout, command and result codes.
// ============================================================================
package rtt_pkg;

    // Command codes on the input word
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SCAN   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Result kinds on the output word
    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_REMOVED   = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_RESEND    = 3'd4;
    localparam logic [2:0] KIND_EXPIRED   = 3'd5;
    localparam logic [2:0] KIND_DONE      = 3'd6;

    // Resend interval after reset, in ms
    localparam logic [15:0] INTERVAL_RESET = 16'd500;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] seq_id;
        logic [7:0]  resend_count;
        logic [31:0] first_due;
        logic [7:0]  buffer_ref;
        logic [9:0]  frame_length;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] seq_id_out;
        logic [7:0]  buffer_out;
        logic [9:0]  length_out;
        logic        retired;
        logic        last;
    } t_out_word;

    // Payload of one table slot
    typedef struct packed {
        logic [15:0] seq;
        logic [7:0]  count;
        logic [31:0] due;
        logic [7:0]  buffer;
        logic [9:0]  length;
    } t_slot;

    typedef struct packed {
        logic  valid;
        t_slot slot;
    } t_entry;

    // Chain moves: hold, push at the front, rotate toward the front,
    // drop the head and close the gap inside the unprocessed region
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_ROTATE,
        CELL_DROP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     below_bound;  // cell lies before the last unprocessed cell
        logic     at_bound;     // cell is the last unprocessed cell
    } t_cell_ctl;

endpackage

/* src/rtt_cell.sv */
// ============================================================================
// rtt_cell: one slot of the timer table chain
// Holds one entry and takes its left or right neighbor on chain moves.
// ============================================================================
module rtt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtt_pkg::t_cell_ctl i_ctl,
    input  rtt_pkg::t_entry   i_left,
    input  rtt_pkg::t_entry   i_right,
    output rtt_pkg::t_entry   o_entry
);

    logic           r_valid;
    rtt_pkg::t_slot r_slot;
    logic           n_valid;
    rtt_pkg::t_slot n_slot;

    // Next entry for this cell
    always_comb begin
        n_valid = r_valid;
        n_slot  = r_slot;
        case (i_ctl.op)
            rtt_pkg::CELL_PUSH: begin
                n_valid = i_left.valid;
                n_slot  = i_left.slot;
            end
            rtt_pkg::CELL_ROTATE: begin
                n_valid = i_right.valid;
                n_slot  = i_right.slot;
            end
            rtt_pkg::CELL_DROP: begin
                if (i_ctl.below_bound) begin
                    n_valid = i_right.valid;
                    n_slot  = i_right.slot;
                end else if (i_ctl.at_bound) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Valid bit clears on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_entry.valid = r_valid;
    assign o_entry.slot  = r_slot;

endmodule

/* src/rtt_ctrl.sv */
// ============================================================================
// rtt_ctrl: timer table sequencer
// Runs commands over the head of the cell chain and drives the result word.
// ============================================================================
module rtt_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int LEFT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rtt_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rtt_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  rtt_pkg::t_entry    i_head,
    input  logic               i_full,
    output rtt_pkg::t_entry    o_new,
    output rtt_pkg::t_entry    o_tail,
    output rtt_pkg::t_cell_op  o_op,
    output logic [LEFT_W-1:0]  o_left
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_ALIGN
    } t_state;

    t_state             r_state, n_state;
    logic [1:0]         r_cmd, n_cmd;
    logic [15:0]        r_seq, n_seq;
    logic [31:0]        r_now, n_now;
    logic [15:0]        r_interval;
    logic               r_found, n_found;
    logic               r_kept, n_kept;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic               r_out_valid, n_out_valid;
    rtt_pkg::t_out_word r_out_word, n_out_word;

    logic               out_free;
    logic               accept;
    logic               due_hit;
    logic [7:0]         count_next;
    logic               retire;
    rtt_pkg::t_entry    upd_entry;
    rtt_pkg::t_cell_op  op;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    // Head entry after a possible resend
    assign due_hit    = (i_head.slot.count != 8'd0) && (i_head.slot.due <= r_now);
    assign count_next = due_hit ? i_head.slot.count - 8'd1 : i_head.slot.count;
    assign retire     = (count_next == 8'd0);

    always_comb begin
        upd_entry = i_head;
        if (due_hit) begin
            upd_entry.slot.due   = r_now + {16'd0, r_interval};
            upd_entry.slot.count = count_next;
        end
    end

    // New entry for an add
    assign o_new.valid       = 1'b1;
    assign o_new.slot.seq    = i_in_word.seq_id;
    assign o_new.slot.count  = i_in_word.resend_count;
    assign o_new.slot.due    = i_in_word.first_due;
    assign o_new.slot.buffer = i_in_word.buffer_ref;
    assign o_new.slot.length = i_in_word.frame_length;

    // Kept entries go back in at the tail; a scan writes back the update
    assign o_tail = ((r_state == ST_WALK) && (r_cmd == rtt_pkg::CMD_SCAN)) ? upd_entry
                                                                          : i_head;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_seq       = r_seq;
        n_now       = r_now;
        n_found     = r_found;
        n_kept      = r_kept;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        op          = rtt_pkg::CELL_HOLD;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd   = i_in_word.cmd;
                    n_seq   = i_in_word.seq_id;
                    n_now   = i_in_word.now_ms;
                    n_found = 1'b0;
                    n_kept  = 1'b0;
                    n_left  = LEFT_W'(TABLE_DEPTH);
                    case (i_in_word.cmd)
                        rtt_pkg::CMD_ADD: begin
                            n_out_valid           = 1'b1;
                            n_out_word.kind       = i_full ? rtt_pkg::KIND_FULL
                                                           : rtt_pkg::KIND_ADDED;
                            n_out_word.seq_id_out = i_in_word.seq_id;
                            n_out_word.buffer_out = i_in_word.buffer_ref;
                            n_out_word.length_out = i_in_word.frame_length;
                            n_out_word.retired    = 1'b0;
                            n_out_word.last       = 1'b1;
                            if (!i_full) begin
                                op = rtt_pkg::CELL_PUSH;
                            end
                        end
                        rtt_pkg::CMD_REMOVE, rtt_pkg::CMD_SCAN: begin
                            n_state = ST_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_WALK: begin
                if ((r_left == '0) || !i_head.valid) begin
                    // Every live entry has been visited
                    if (r_cmd == rtt_pkg::CMD_SCAN) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out_word  = '0;
                            n_out_word.kind = rtt_pkg::KIND_DONE;
                            n_out_word.last = 1'b1;
                            n_state = ST_ALIGN;
                        end
                    end else if (r_found) begin
                        n_state = ST_ALIGN;
                    end else if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_word  = '0;
                        n_out_word.kind       = rtt_pkg::KIND_NOT_FOUND;
                        n_out_word.seq_id_out = r_seq;
                        n_out_word.last       = 1'b1;
                        n_state = ST_ALIGN;
                    end
                end else if (r_cmd == rtt_pkg::CMD_SCAN) begin
                    if (!(due_hit || retire) || out_free) begin
                        n_left = r_left - LEFT_W'(1);
                        // Word fields only change when a word goes out
                        if (due_hit || retire) begin
                            n_out_word.seq_id_out = i_head.slot.seq;
                            n_out_word.buffer_out = i_head.slot.buffer;
                            n_out_word.length_out = i_head.slot.length;
                            n_out_word.last       = 1'b0;
                        end
                        if (retire) begin
                            op = rtt_pkg::CELL_DROP;
                            n_out_valid        = 1'b1;
                            n_out_word.kind    = due_hit ? rtt_pkg::KIND_RESEND
                                                         : rtt_pkg::KIND_EXPIRED;
                            n_out_word.retired = 1'b1;
                        end else begin
                            op     = rtt_pkg::CELL_ROTATE;
                            n_kept = 1'b1;
                            if (due_hit) begin
                                n_out_valid        = 1'b1;
                                n_out_word.kind    = rtt_pkg::KIND_RESEND;
                                n_out_word.retired = 1'b0;
                            end
                        end
                    end
                end else begin
                    // Remove: newest matching entry only
                    if (!r_found && (i_head.slot.seq == r_seq)) begin
                        if (out_free) begin
                            op      = rtt_pkg::CELL_DROP;
                            n_found = 1'b1;
                            n_left  = r_left - LEFT_W'(1);
                            n_out_valid           = 1'b1;
                            n_out_word.kind       = rtt_pkg::KIND_REMOVED;
                            n_out_word.seq_id_out = r_seq;
                            n_out_word.buffer_out = i_head.slot.buffer;
                            n_out_word.length_out = i_head.slot.length;
                            n_out_word.retired    = 1'b0;
                            n_out_word.last       = 1'b1;
                        end
                    end else begin
                        op     = rtt_pkg::CELL_ROTATE;
                        n_kept = 1'b1;
                        n_left = r_left - LEFT_W'(1);
                    end
                end
            end

            ST_ALIGN: begin
                // Rotate the free slots past the kept block
                if (i_head.valid || !r_kept) begin
                    n_state = ST_IDLE;
                end else begin
                    op = rtt_pkg::CELL_ROTATE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_found     <= 1'b0;
            r_kept      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_interval  <= rtt_pkg::INTERVAL_RESET;
        end else begin
            r_state     <= n_state;
            r_found     <= n_found;
            r_kept      <= n_kept;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_interval <= i_cfg_data;
            end
            r_cmd      <= n_cmd;
            r_seq      <= n_seq;
            r_now      <= n_now;
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_op        = op;
    assign o_left      = r_left;

endmodule

/* src/retransmit_timer_table_top.sv */
// ============================================================================
// retransmit_timer_table_top: retransmission timer table
// Bounded table of pending frames, newest first, held in a chain of cells.
// ============================================================================
// Input words (i_in_word) are taken when i_in_valid is high and o_in_stall
// is low. cmd selects add, remove by sequence id, or scan at now_ms; code 3
// is taken and ignored. Result words leave on o_out_word with o_out_valid
// and are held while i_out_stall is high; last marks the final word of an
// item. i_cfg_we writes the resend interval (ms) from i_cfg_data.
// Sequence of an item, with n live entries before it:
//   add: the result word appears in the cycle after acceptance.
//   remove, scan: the entries walk through the head cell, then the freed
//   slots rotate behind the kept ones (this step ends at once when nothing
//   is kept), and the block returns to idle to take the next word. A scan
//   gives up to n + 1 words, one per cycle while the receiver does not stall.
// The walk pauses whenever a word is due and the output register is held
// by a stalled receiver. Reset empties the table at once and sets the
// interval to 500 ms; no clearing pass is needed.
// ============================================================================
module retransmit_timer_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rtt_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rtt_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data
);

    localparam int LEFT_W = $clog2(TABLE_DEPTH + 1);

    rtt_pkg::t_entry   w_cell [TABLE_DEPTH];
    rtt_pkg::t_entry   w_new;
    rtt_pkg::t_entry   w_tail;
    rtt_pkg::t_cell_op w_op;
    logic [LEFT_W-1:0] w_left;

    // Sequencer
    rtt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .LEFT_W      (LEFT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_cell[0]),
        .i_full      (w_cell[TABLE_DEPTH-1].valid),
        .o_new       (w_new),
        .o_tail      (w_tail),
        .o_op        (w_op),
        .o_left      (w_left)
    );

    // Cell chain, slot 0 is the newest entry
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        rtt_pkg::t_cell_ctl w_ctl;
        rtt_pkg::t_entry    w_left_in;
        rtt_pkg::t_entry    w_right_in;

        assign w_ctl.op          = w_op;
        assign w_ctl.below_bound = (w_left > LEFT_W'(i + 1));
        assign w_ctl.at_bound    = (w_left == LEFT_W'(i + 1));

        if (i == 0) begin : g_first
            assign w_left_in = w_new;
        end else begin : g_mid_l
            assign w_left_in = w_cell[i-1];
        end

        if (i == TABLE_DEPTH - 1) begin : g_last
            assign w_right_in = w_tail;
        end else begin : g_mid_r
            assign w_right_in = w_cell[i+1];
        end

        rtt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left_in),
            .i_right (w_right_in),
            .o_entry (w_cell[i])
        );
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top: retransmit timer table testbench
// Drives add, remove and scan commands with random gaps on both sides,
// predicts every result word from a model of the table kept here, and
// compares each accepted result word field by field.
// ============================================================================
module tb_top;

    localparam int DEPTH          = 16;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    // Table model and queue of predicted result words
    class timer_table_scoreboard;
        rtt_pkg::t_slot     live_entries[$];   // index 0 is the newest entry
        rtt_pkg::t_out_word expected_words[$];
        logic [15:0]        interval_ms;
        int                 mismatches;

        function new();
            interval_ms = rtt_pkg::INTERVAL_RESET;
            mismatches  = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void expect_word(logic [2:0] kind, logic [15:0] seq, logic [7:0] buffer,
                                  logic [9:0] length, logic retired, logic last);
            rtt_pkg::t_out_word o;
            o.kind       = kind;
            o.seq_id_out = seq;
            o.buffer_out = buffer;
            o.length_out = length;
            o.retired    = retired;
            o.last       = last;
            expected_words.push_back(o);
        endfunction

        // Apply one accepted command word to the table model
        function void note_command(rtt_pkg::t_in_word w);
            rtt_pkg::t_slot s;
            rtt_pkg::t_slot kept[$];
            int             hit;
            bit             sent;
            case (w.cmd)
                rtt_pkg::CMD_ADD: begin
                    if (live_entries.size() >= DEPTH) begin
                        expect_word(rtt_pkg::KIND_FULL, w.seq_id, w.buffer_ref,
                                    w.frame_length, 1'b0, 1'b1);
                    end else begin
                        s.seq    = w.seq_id;
                        s.count  = w.resend_count;
                        s.due    = w.first_due;
                        s.buffer = w.buffer_ref;
                        s.length = w.frame_length;
                        live_entries.push_front(s);
                        expect_word(rtt_pkg::KIND_ADDED, w.seq_id, w.buffer_ref,
                                    w.frame_length, 1'b0, 1'b1);
                    end
                end
                rtt_pkg::CMD_REMOVE: begin
                    // newest matching entry goes
                    hit = -1;
                    foreach (live_entries[i])
                        if (hit < 0 && live_entries[i].seq == w.seq_id) hit = i;
                    if (hit >= 0) begin
                        expect_word(rtt_pkg::KIND_REMOVED, w.seq_id, live_entries[hit].buffer,
                                    live_entries[hit].length, 1'b0, 1'b1);
                        live_entries.delete(hit);
                    end else begin
                        expect_word(rtt_pkg::KIND_NOT_FOUND, w.seq_id, 8'h00, 10'h000,
                                    1'b0, 1'b1);
                    end
                end
                rtt_pkg::CMD_SCAN: begin
                    foreach (live_entries[i]) begin
                        s    = live_entries[i];
                        sent = 1'b0;
                        if (s.count != 0 && s.due <= w.now_ms) begin
                            s.due   = w.now_ms + 32'(interval_ms);
                            s.count = s.count - 8'd1;
                            sent    = 1'b1;
                        end
                        if (s.count == 0) begin
                            // zero count retires, with or without a resend
                            expect_word(sent ? rtt_pkg::KIND_RESEND : rtt_pkg::KIND_EXPIRED,
                                        s.seq, s.buffer, s.length, 1'b1, 1'b0);
                        end else begin
                            if (sent)
                                expect_word(rtt_pkg::KIND_RESEND, s.seq, s.buffer, s.length,
                                            1'b0, 1'b0);
                            kept.push_back(s);
                        end
                    end
                    live_entries = kept;
                    expect_word(rtt_pkg::KIND_DONE, 16'h0000, 8'h00, 10'h000, 1'b0, 1'b1);
                end
                default: ;   // unused code: no change, no word
            endcase
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void check_word(rtt_pkg::t_out_word got);
            rtt_pkg::t_out_word want;
            if (expected_words.size() == 0) begin
                flag($sformatf("unexpected word kind=%0d seq=%h buf=%h len=%0d ret=%b last=%b",
                               got.kind, got.seq_id_out, got.buffer_out, got.length_out,
                               got.retired, got.last));
                return;
            end
            want = expected_words.pop_front();
            if (got.kind !== want.kind || got.seq_id_out !== want.seq_id_out ||
                got.buffer_out !== want.buffer_out || got.length_out !== want.length_out ||
                got.retired !== want.retired || got.last !== want.last)
                flag($sformatf({"mismatch: expected kind=%0d seq=%h buf=%h len=%0d ret=%b ",
                                "last=%b, got kind=%0d seq=%h buf=%h len=%0d ret=%b last=%b"},
                               want.kind, want.seq_id_out, want.buffer_out, want.length_out,
                               want.retired, want.last, got.kind, got.seq_id_out,
                               got.buffer_out, got.length_out, got.retired, got.last));
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    rtt_pkg::t_in_word  in_word   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    rtt_pkg::t_out_word out_word;
    logic               cfg_we    = 1'b0;
    logic [15:0]        cfg_data  = '0;

    timer_table_scoreboard sb;
    logic [31:0] clock_ms    = '0;
    bit          tx_idle     = 1'b1;
    bit          rx_idle     = 1'b1;
    bit          hold_req    = 1'b0;
    int          idle_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    retransmit_timer_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Result monitor and watchdog on cycles without any accepted word
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stall before each word, one long hold-off on request
    initial begin : receiver
        int hold;
        int words;
        words = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                if (words % 16 == 0) rx_idle = ($urandom_range(0, 3) != 0);
                hold = rx_idle ? $urandom_range(0, 16) : 0;
                if (hold > 0) begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            words++;
        end
    end

    // Offer one command word after a random gap; returns at its acceptance edge
    task automatic send_word(input rtt_pkg::t_in_word w);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sb.note_command(w);
    endtask

    // Write the interval once the table has gone quiet
    task automatic write_interval(input logic [15:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.interval_ms = value;
    endtask

    function automatic rtt_pkg::t_in_word cmd_word(logic [1:0] cmd, logic [15:0] seq,
                                                   logic [7:0] count, logic [31:0] due,
                                                   logic [7:0] buffer, logic [9:0] length,
                                                   logic [31:0] now);
        rtt_pkg::t_in_word w;
        w.cmd          = cmd;
        w.seq_id       = seq;
        w.resend_count = count;
        w.first_due    = due;
        w.buffer_ref   = buffer;
        w.frame_length = length;
        w.now_ms       = now;
        return w;
    endfunction

    function automatic rtt_pkg::t_in_word random_word();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return r[$bits(rtt_pkg::t_in_word)-1:0];
    endfunction

    function automatic logic [15:0] live_id();
        return sb.live_entries[$urandom_range(0, sb.live_entries.size() - 1)].seq;
    endfunction

    // Adds: small counts and due times around the running clock, mostly
    function automatic rtt_pkg::t_in_word make_add();
        rtt_pkg::t_in_word w;
        w     = random_word();
        w.cmd = rtt_pkg::CMD_ADD;
        if (sb.live_entries.size() != 0 && $urandom_range(0, 4) == 0) w.seq_id = live_id();
        if ($urandom_range(0, 7) != 0) w.resend_count = 8'($urandom_range(0, 4));
        if ($urandom_range(0, 9) != 0)
            w.first_due = clock_ms + $urandom_range(0, 3 * sb.interval_ms) - sb.interval_ms;
        return w;
    endfunction

    function automatic rtt_pkg::t_in_word make_remove();
        rtt_pkg::t_in_word w;
        w     = random_word();
        w.cmd = rtt_pkg::CMD_REMOVE;
        if (sb.live_entries.size() != 0 && $urandom_range(0, 3) != 0) w.seq_id = live_id();
        return w;
    endfunction

    function automatic rtt_pkg::t_in_word make_scan();
        rtt_pkg::t_in_word w;
        w        = random_word();
        w.cmd    = rtt_pkg::CMD_SCAN;
        clock_ms = clock_ms + $urandom_range(0, 2 * sb.interval_ms);
        w.now_ms = clock_ms;
        return w;
    endfunction

    // Random traffic: mostly well-formed commands, some raw words, fill bursts
    task automatic run_random(input int item_target);
        int                counted;
        int                pick;
        rtt_pkg::t_in_word w;
        counted = 0;
        while (counted < item_target) begin
            if (counted % 16 == 0) tx_idle = ($urandom_range(0, 3) != 0);
            if (counted == 0 || $urandom_range(0, 15) == 0) begin
                // run the table up to full, then overflow it
                while (sb.live_entries.size() < DEPTH) begin
                    send_word(make_add());
                    counted++;
                end
                repeat (2) begin
                    send_word(make_add());
                    counted++;
                end
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 15)      w = random_word();
                else if (pick < 50) w = make_add();
                else if (pick < 65) w = make_remove();
                else                w = make_scan();
                send_word(w);
                if (w.cmd != rtt_pkg::CMD_NONE) counted++;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset interval
        send_word(cmd_word(rtt_pkg::CMD_SCAN, 16'h0000, 8'h00, 32'h0, 8'h00, 10'h000, 32'h0));
        send_word(cmd_word(rtt_pkg::CMD_REMOVE, 16'hFFFF, 8'hFF, '1, 8'hFF, 10'h3FF, '1));
        send_word(cmd_word(rtt_pkg::CMD_ADD, 16'h0000, 8'h00, 32'h0, 8'h00, 10'h000, '1));
        send_word(cmd_word(rtt_pkg::CMD_ADD, 16'hFFFF, 8'hFF, '1, 8'hFF, 10'h3FF, 32'h0));
        send_word(cmd_word(rtt_pkg::CMD_ADD, 16'h1234, 8'd1, 32'd100, 8'h5A, 10'd64, 32'h0));
        send_word(cmd_word(rtt_pkg::CMD_ADD, 16'h1234, 8'd2, 32'd0, 8'hA5, 10'd512, 32'h0));
        send_word(cmd_word(rtt_pkg::CMD_NONE, '1, '1, '1, '1, '1, '1));
        // both 1234 entries resend (older one retires), zero-count entry expires
        send_word(cmd_word(rtt_pkg::CMD_SCAN, 16'h0000, 8'h00, 32'h0, 8'h00, 10'h000,
                           32'd100));
        send_word(cmd_word(rtt_pkg::CMD_REMOVE, 16'h1234, 8'h00, 32'h0, 8'h00, 10'h000,
                           32'h0));
        send_word(cmd_word(rtt_pkg::CMD_REMOVE, 16'h1234, 8'h00, 32'h0, 8'h00, 10'h000,
                           32'h0));
        // due time wraps past the top of the 32-bit range
        send_word(cmd_word(rtt_pkg::CMD_SCAN, 16'h0000, 8'h00, 32'h0, 8'h00, 10'h000, '1));
        send_word(cmd_word(rtt_pkg::CMD_SCAN, 16'h0000, 8'h00, 32'h0, 8'h00, 10'h000,
                           32'd498));
        send_word(cmd_word(rtt_pkg::CMD_SCAN, 16'h0000, 8'h00, 32'h0, 8'h00, 10'h000,
                           32'd499));
        send_word(cmd_word(rtt_pkg::CMD_ADD, 16'h0007, 8'd1, 32'd5000, 8'h11, 10'd1, 32'h0));
        send_word(cmd_word(rtt_pkg::CMD_ADD, 16'h0008, 8'd3, 32'd2000, 8'h22, 10'd2, 32'h0));
        // remove from the middle, then compact around a resend
        send_word(cmd_word(rtt_pkg::CMD_REMOVE, 16'h0007, 8'h00, 32'h0, 8'h00, 10'h000,
                           32'h0));
        send_word(cmd_word(rtt_pkg::CMD_SCAN, 16'h0000, 8'h00, 32'h0, 8'h00, 10'h000,
                           32'd1000));

        write_interval(16'd1);
        clock_ms = 32'd1000;
        run_random(80);

        // long receiver hold-off while commands keep coming
        write_interval(16'hFFFF);
        hold_req = 1'b1;
        run_random(90);

        write_interval(16'($urandom_range(2, 65534)));
        clock_ms = 32'hFFFF_F000;
        run_random(90);

        write_interval(rtt_pkg::INTERVAL_RESET);
        run_random(90);

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/rtt_pkg.sv
src/rtt_cell.sv
src/rtt_ctrl.sv
src/retransmit_timer_table_top.sv
dv/tb_top.sv
